// ===== sv/sorted_column_segmenter_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted column segmenter
// Shared concurrent assertion wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_COLUMN_SEGMENTER_CORE_MACROS_SVH
`define SORTED_COLUMN_SEGMENTER_CORE_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define SCS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("scs assertion failed");

// Check a property on every clock edge, reset included.
`define SCS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("scs assertion failed");

`endif

// ===== sv/scs_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted column segmenter package
// Widths, codes, descriptor type and the segment close function.
// ----------------------------------------------------------------------------
package scs_pkg;

  localparam int IDX_W   = 32;
  localparam int VAL_W   = 64;
  localparam int CFG_W   = 32;
  localparam int KIND_W  = 2;
  localparam int MODE_W  = 2;

  localparam logic [CFG_W-1:0] MIN_DELTA_RESET = CFG_W'(5);

  // Segment tracking modes
  localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PENDING = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RUN     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_INC     = 2'd3;

  // Descriptor kinds
  localparam logic [KIND_W-1:0] KIND_DELTA = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RAW   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD   = 2'd3;

  // Descriptor queue depth
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [IDX_W-1:0]  seg_start;
    logic [KIND_W-1:0] seg_kind;
    logic [IDX_W-1:0]  store_index;
    logic [IDX_W-1:0]  seg_length;
    logic [VAL_W-1:0]  first_value;
    logic              final_segment;
  } desc_t;

  typedef struct packed {
    logic [IDX_W-1:0] delta;
    logic [IDX_W-1:0] run;
    logic [IDX_W-1:0] raw;
  } counts_t;

  typedef struct packed {
    desc_t   d;
    counts_t c;
  } close_t;

  // Push request into the descriptor queue: slot a first, then slot b
  typedef struct packed {
    logic  a_en;
    logic  b_en;
    desc_t a;
    desc_t b;
  } push_t;

  // Build the descriptor of the open segment and advance its store count
  function automatic close_t close_seg(
    input logic [MODE_W-1:0] mode,
    input logic [IDX_W-1:0]  start,
    input logic [IDX_W-1:0]  len,
    input logic [VAL_W-1:0]  first,
    input counts_t           cnt,
    input logic [CFG_W-1:0]  thr,
    input logic              fin
  );
    close_t r;
    r.c = cnt;
    r.d.seg_start     = start;
    r.d.seg_length    = len;
    r.d.first_value   = first;
    r.d.final_segment = fin;
    if (mode == MODE_INC) begin
      if (64'(len) < 64'(thr)) begin
        r.d.seg_kind    = KIND_RAW;
        r.d.store_index = cnt.raw;
        r.c.raw         = cnt.raw + len;
      end else begin
        r.d.seg_kind    = KIND_DELTA;
        r.d.store_index = cnt.delta;
        r.c.delta       = cnt.delta + IDX_W'(1);
      end
    end else begin
      r.d.seg_kind    = KIND_RUN;
      r.d.store_index = cnt.run;
      r.c.run         = cnt.run + IDX_W'(1);
    end
    return r;
  endfunction

  // Grow a segment length, saturating at all ones
  function automatic logic [IDX_W-1:0] grow_len(input logic [IDX_W-1:0] len);
    return (len == {IDX_W{1'b1}}) ? len : len + IDX_W'(1);
  endfunction

endpackage

// ===== sv/scs_ifs.sv =====
// ----------------------------------------------------------------------------
// Sorted column segmenter channel interfaces
// Item, descriptor and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface scs_item_if import scs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] value;
  logic             last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

interface scs_desc_if import scs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  seg_start;
  logic [KIND_W-1:0] seg_kind;
  logic [IDX_W-1:0]  store_index;
  logic [IDX_W-1:0]  seg_length;
  logic [VAL_W-1:0]  first_value;
  logic              final_segment;

  modport source (output valid, seg_start, seg_kind, store_index, seg_length,
                  first_value, final_segment, input ready);
  modport sink   (input valid, seg_start, seg_kind, store_index, seg_length,
                  first_value, final_segment, output ready);
endinterface

interface scs_cfg_if import scs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== sv/scs_desc_fifo.sv =====
// ----------------------------------------------------------------------------
// Descriptor queue
// Small register queue taking up to two descriptors per cycle, one out.
// ----------------------------------------------------------------------------
module scs_desc_fifo import scs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  push_t       push,
  output logic        room2,
  scs_desc_if.source  desc
);

  desc_t            mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             pop;
  logic [CNT_W-1:0] push_n;
  desc_t            head;

  assign pop    = desc.valid && desc.ready;
  assign push_n = CNT_W'(push.a_en) + CNT_W'(push.b_en);
  assign room2  = (count <= CNT_W'(FIFO_DEPTH - 2));

  // Occupancy after this cycle's pushes and pop
  always_comb begin
    count_next = count + push_n - CNT_W'(pop);
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

  // Store pushed beats
  always_ff @(posedge clk) begin
    if (push.a_en) begin
      mem[wr_ptr] <= push.a;
    end
    if (push.b_en) begin
      mem[wr_ptr + PTR_W'(1)] <= push.b;
    end
  end

  // Drive the head beat
  assign head               = mem[rd_ptr];
  assign desc.valid         = (count != '0);
  assign desc.seg_start     = head.seg_start;
  assign desc.seg_kind      = head.seg_kind;
  assign desc.store_index   = head.store_index;
  assign desc.seg_length    = head.seg_length;
  assign desc.first_value   = head.first_value;
  assign desc.final_segment = head.final_segment;

endmodule

// ===== sv/sorted_column_segmenter_core.sv =====
// ----------------------------------------------------------------------------
// Sorted column segmenter core
// Cuts a column of 64-bit values into run, delta and raw segments.
// ----------------------------------------------------------------------------
// The block accepts one column value per cycle while the queue has room and
// emits one descriptor per closed segment. An accepted value is held in an
// input register, where the segment state is updated and zero, one or two
// descriptors are pushed into a four-entry descriptor queue; the first
// descriptor is valid at the output once its queue entry is written, and
// leaves when the output is ready. The input takes a value whenever the queue
// has two free entries, so with the output ready the sustained rate is one
// value per cycle; the output drains one descriptor per cycle while ready,
// and a column ending on a segment break yields two descriptors from one
// value. After the value marked last, all counts and indexes restart at zero
// for the next column; min_delta_length keeps its value.
// ----------------------------------------------------------------------------
module sorted_column_segmenter_core import scs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  scs_item_if.sink   item,
  scs_desc_if.source desc,
  scs_cfg_if.sink    cfg
);

  // Configuration
  logic [CFG_W-1:0]  min_delta_length;

  // Input register
  logic              s0_valid;
  logic [VAL_W-1:0]  s0_value;
  logic              s0_last;
  logic              s0_fire;
  logic              room2;

  // Segment state
  logic [VAL_W-1:0]  previous_value;
  logic [MODE_W-1:0] mode;
  logic [IDX_W-1:0]  segment_start;
  logic [IDX_W-1:0]  segment_length;
  logic [VAL_W-1:0]  segment_first;
  logic [IDX_W-1:0]  item_index;
  counts_t           counts;

  // Step results
  logic [MODE_W-1:0] mode_next;
  logic [IDX_W-1:0]  start_next;
  logic [IDX_W-1:0]  length_next;
  logic [VAL_W-1:0]  first_next;
  counts_t           counts_next;
  logic              brk;
  logic              rise;
  close_t            c0;
  close_t            c1;
  push_t             push;

  // Always take configuration beats
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_delta_length <= MIN_DELTA_RESET;
    end else if (cfg.valid) begin
      min_delta_length <= cfg.data;
    end
  end

  // Hold an item until the queue has room for two descriptors
  assign s0_fire    = s0_valid && room2;
  assign item.ready = !s0_valid || s0_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      s0_valid <= 1'b1;
    end else if (s0_fire) begin
      s0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s0_value <= item.value;
      s0_last  <= item.last;
    end
  end

  // Step the segment state for the registered item
  always_comb begin
    mode_next   = mode;
    start_next  = segment_start;
    length_next = segment_length;
    first_next  = segment_first;
    counts_next = counts;
    brk         = 1'b0;
    rise        = (previous_value < s0_value);
    case (mode)
      MODE_PENDING: begin
        mode_next   = (segment_first < s0_value) ? MODE_INC : MODE_RUN;
        length_next = grow_len(segment_length);
      end
      MODE_RUN: begin
        if (!rise) begin
          length_next = grow_len(segment_length);
        end else begin
          brk = 1'b1;
        end
      end
      MODE_INC: begin
        if (rise) begin
          length_next = grow_len(segment_length);
        end else begin
          brk = 1'b1;
        end
      end
      default: begin
        mode_next   = MODE_PENDING;
        start_next  = item_index;
        length_next = IDX_W'(1);
        first_next  = s0_value;
      end
    endcase

    // Close the broken segment and open one at this item
    c0 = close_seg(mode, segment_start, segment_length, segment_first, counts,
                   min_delta_length, 1'b0);
    if (brk) begin
      counts_next = c0.c;
      mode_next   = MODE_PENDING;
      start_next  = item_index;
      length_next = IDX_W'(1);
      first_next  = s0_value;
    end

    // Close the segment that ends the column
    c1 = close_seg(mode_next, start_next, length_next, first_next, counts_next,
                   min_delta_length, 1'b1);
  end

  // Queue the descriptors in order
  always_comb begin
    push.a_en = s0_fire && (brk || s0_last);
    push.b_en = s0_fire && brk && s0_last;
    push.a    = brk ? c0.d : c1.d;
    push.b    = c1.d;
  end

  // Commit state; clear it at the end of a column
  always_ff @(posedge clk) begin
    if (rst || (s0_fire && s0_last)) begin
      previous_value <= '0;
      mode           <= MODE_IDLE;
      segment_start  <= '0;
      segment_length <= '0;
      segment_first  <= '0;
      item_index     <= '0;
      counts         <= '0;
    end else if (s0_fire) begin
      previous_value <= s0_value;
      mode           <= mode_next;
      segment_start  <= start_next;
      segment_length <= length_next;
      segment_first  <= first_next;
      item_index     <= item_index + IDX_W'(1);
      counts         <= counts_next;
    end
  end

  scs_desc_fifo u_desc_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .room2 (room2),
    .desc  (desc)
  );

endmodule

// ===== sv/scs_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted column segmenter port checker
// Watches the top-level ports for reset and descriptor rules.
// ----------------------------------------------------------------------------
`include "sorted_column_segmenter_core_macros.svh"

module scs_checker import scs_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              item_ready,
  input logic              desc_valid,
  input logic              desc_ready,
  input logic [IDX_W-1:0]  desc_seg_start,
  input logic [KIND_W-1:0] desc_seg_kind,
  input logic [IDX_W-1:0]  desc_store_index,
  input logic [IDX_W-1:0]  desc_seg_length,
  input logic [VAL_W-1:0]  desc_first_value,
  input logic              desc_final_segment
);

  // Reset empties the block: no beat out, input open
  `SCS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (!desc_valid && item_ready))

  // A stalled descriptor beat stays and holds its payload
  `SCS_ASSERT(a_desc_hold, clk, rst,
    (desc_valid && !desc_ready) |=> (desc_valid && $stable(desc_seg_start)
      && $stable(desc_seg_kind) && $stable(desc_store_index)
      && $stable(desc_seg_length) && $stable(desc_first_value)
      && $stable(desc_final_segment)))

  // Every descriptor has a legal kind and a nonzero length
  `SCS_ASSERT(a_desc_legal, clk, rst,
    desc_valid |-> (desc_seg_kind != KIND_BAD && desc_seg_length != '0))

endmodule

bind sorted_column_segmenter_core scs_checker u_scs_checker (
  .clk                (clk),
  .rst                (rst),
  .item_ready         (item.ready),
  .desc_valid         (desc.valid),
  .desc_ready         (desc.ready),
  .desc_seg_start     (desc.seg_start),
  .desc_seg_kind      (desc.seg_kind),
  .desc_store_index   (desc.store_index),
  .desc_seg_length    (desc.seg_length),
  .desc_first_value   (desc.first_value),
  .desc_final_segment (desc.final_segment)
);
